[hw/rtl/microwire_eeprom_master_top_macros.svh]
// assertion macros shared by the microwire master rtl
// the checked signals are sampled on clk_i; MW_ASSERT ignores them while rst_ni is low
`ifndef MICROWIRE_EEPROM_MASTER_TOP_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property checked outside reset
`define MW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define MW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define MW_ASSERT(lbl, prop, msg)
`define MW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/mw_pkg.sv]
package mw_pkg;

  // item field widths as seen on the ports
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned IDX_IN_W    = 6;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned POLL_W      = 14;

  // item mode codes (the unused code behaves as a tick)
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  // start bit plus opcode heading each frame
  localparam logic [2:0] OP_READ  = 3'b110;
  localparam logic [2:0] OP_WRITE = 3'b101;
  localparam logic [2:0] OP_EWX   = 3'b100;  // ewen / ewds, told apart by the address bits

  // poll limit after reset, and the saturation point of the poll counter
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 14'd10000;
  localparam logic [POLL_W-1:0] POLL_MAX       = 14'h3FFF;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [IDX_IN_W-1:0] word_index;
    logic [WORD_W-1:0]   write_word;
    logic                data_out_level;
  } mw_in_t;

  typedef struct packed {
    logic              chip_select;
    logic              serial_clock;
    logic              data_in_level;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] read_result;
    logic              write_ok;
    logic              rejected;
  } mw_out_t;

endpackage

[hw/rtl/mw_core.sv]
`include "microwire_eeprom_master_top_macros.svh"

module mw_core import mw_pkg::*; #(
  parameter int unsigned ADDR_BITS = 6,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [POLL_W-1:0] cfg_wdata_i,
  input  logic              item_valid_i,
  input  mw_in_t            item_i,
  output mw_out_t           res_o
);

  localparam int unsigned CMD_LEN   = ADDR_BITS + 3;
  localparam int unsigned FRAME_LEN = CMD_LEN + DATA_BITS;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_EWEN     = 4'd1,
    ST_GAP_W    = 4'd2,
    ST_WRITE    = 4'd3,
    ST_DUM_RISE = 4'd4,
    ST_DUM_FALL = 4'd5,
    ST_POLL_SEL = 4'd6,
    ST_POLL     = 4'd7,
    ST_GAP_D    = 4'd8,
    ST_EWDS     = 4'd9,
    ST_RD_ADDR  = 4'd10,
    ST_RD_DATA  = 4'd11
  } step_e;

  step_e                step_q, step_d;
  logic [FRAME_LEN-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 phase_q, phase_d;
  logic [DATA_BITS-1:0] acc_q, acc_d;
  logic [POLL_W-1:0]    poll_q, poll_d;
  logic                 cs_q, cs_d;
  logic                 sclk_q, sclk_d;
  logic                 di_q, di_d;
  logic [POLL_W-1:0]    limit_q;

  // frame bit at position cnt - 1, zero once the counter is empty
  function automatic logic frame_bit(step_e st, logic [FRAME_LEN-1:0] shf,
                                     logic [CNT_W-1:0] cnt);
    logic [FRAME_LEN-1:0] pat;
    logic [IDX_W-1:0]     idx;
    case (st)
      ST_EWEN: pat = FRAME_LEN'({OP_EWX, {ADDR_BITS{1'b1}}});
      ST_EWDS: pat = FRAME_LEN'({OP_EWX, {ADDR_BITS{1'b0}}});
      default: pat = shf;
    endcase
    idx = IDX_W'(cnt - 1'b1);
    return (cnt != '0) && pat[idx];
  endfunction

  logic                 is_cmd;
  logic [ADDR_BITS-1:0] addr;
  logic [DATA_BITS-1:0] word;
  logic [CNT_W-1:0]     cnt_dec;
  logic                 frame_end;
  logic                 bit_next;
  logic [POLL_W-1:0]    limit;
  logic [POLL_W-1:0]    poll_inc;
  logic [DATA_BITS-1:0] acc_shift;
  logic                 done;
  logic                 wok;
  logic                 rej;
  logic [DATA_BITS-1:0] rd;

  // shared pieces of the half bit step
  assign is_cmd    = (item_i.mode == MODE_READ) || (item_i.mode == MODE_WRITE);
  assign addr      = ADDR_BITS'(item_i.word_index);
  assign word      = DATA_BITS'(item_i.write_word);
  assign cnt_dec   = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
  assign frame_end = phase_q && (cnt_dec == '0);
  assign bit_next  = frame_bit(step_q, shift_q, cnt_dec);
  assign limit     = (limit_q == '0) ? POLL_W'(1) : limit_q;
  assign poll_inc  = (poll_q != POLL_MAX) ? poll_q + 1'b1 : poll_q;
  assign acc_shift = {acc_q[DATA_BITS-2:0], item_i.data_out_level};

  // sequencer next state for one item
  always_comb begin
    step_d  = step_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    acc_d   = acc_q;
    poll_d  = poll_q;
    cs_d    = cs_q;
    sclk_d  = sclk_q;
    di_d    = di_q;
    done    = 1'b0;
    wok     = 1'b0;
    rej     = 1'b0;
    rd      = '0;
    if (item_valid_i) begin
      if (is_cmd) begin
        if (step_q != ST_IDLE) begin
          rej = 1'b1;
        end else begin
          phase_d = 1'b0;
          cnt_d   = CNT_W'(CMD_LEN);
          acc_d   = '0;
          poll_d  = '0;
          cs_d    = 1'b1;
          sclk_d  = 1'b0;
          di_d    = 1'b1;
          if (item_i.mode == MODE_WRITE) begin
            shift_d = {OP_WRITE, addr, word};
            step_d  = ST_EWEN;
          end else begin
            shift_d = FRAME_LEN'({OP_READ, addr});
            step_d  = ST_RD_ADDR;
          end
        end
      end else begin
        case (step_q)
          ST_IDLE: begin
            step_d = ST_IDLE;
          end
          ST_EWEN, ST_WRITE, ST_EWDS, ST_RD_ADDR: begin
            phase_d = !phase_q;
            sclk_d  = !phase_q;
            if (phase_q) begin
              cnt_d = cnt_dec;
              if (!frame_end) begin
                di_d = bit_next;
              end else begin
                case (step_q)
                  ST_EWEN: begin
                    cs_d   = 1'b0;
                    step_d = ST_GAP_W;
                  end
                  ST_WRITE: begin
                    cs_d   = 1'b0;
                    di_d   = 1'b0;
                    step_d = ST_DUM_RISE;
                  end
                  ST_EWDS: begin
                    cs_d   = 1'b0;
                    step_d = ST_IDLE;
                    done   = 1'b1;
                    wok    = acc_q[0];
                  end
                  default: begin
                    step_d = ST_RD_DATA;
                    cnt_d  = CNT_W'(DATA_BITS);
                    acc_d  = '0;
                  end
                endcase
              end
            end
          end
          ST_GAP_W: begin
            step_d  = ST_WRITE;
            cnt_d   = CNT_W'(FRAME_LEN);
            phase_d = 1'b0;
            cs_d    = 1'b1;
            di_d    = frame_bit(ST_WRITE, shift_q, CNT_W'(FRAME_LEN));
          end
          ST_DUM_RISE: begin
            sclk_d = 1'b1;
            step_d = ST_DUM_FALL;
          end
          ST_DUM_FALL: begin
            sclk_d = 1'b0;
            step_d = ST_POLL_SEL;
          end
          ST_POLL_SEL: begin
            cs_d   = 1'b1;
            poll_d = '0;
            step_d = ST_POLL;
          end
          ST_POLL: begin
            if (item_i.data_out_level) begin
              acc_d  = DATA_BITS'(1);
              cs_d   = 1'b0;
              step_d = ST_GAP_D;
            end else begin
              poll_d = poll_inc;
              if (poll_inc >= limit) begin
                acc_d  = '0;
                cs_d   = 1'b0;
                step_d = ST_GAP_D;
              end
            end
          end
          ST_GAP_D: begin
            step_d  = ST_EWDS;
            cnt_d   = CNT_W'(CMD_LEN);
            phase_d = 1'b0;
            cs_d    = 1'b1;
            di_d    = frame_bit(ST_EWDS, shift_q, CNT_W'(CMD_LEN));
          end
          ST_RD_DATA: begin
            phase_d = !phase_q;
            sclk_d  = !phase_q;
            if (phase_q) begin
              acc_d = acc_shift;
              cnt_d = cnt_dec;
              if (cnt_dec == '0) begin
                cs_d   = 1'b0;
                step_d = ST_IDLE;
                done   = 1'b1;
                rd     = acc_shift;
              end
            end
          end
          default: begin
            step_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  // result of the item, taken by the output queue
  always_comb begin
    res_o.chip_select   = cs_d;
    res_o.serial_clock  = sclk_d;
    res_o.data_in_level = di_d;
    res_o.busy_res      = (step_d != ST_IDLE);
    res_o.done_res      = done;
    res_o.read_result   = WORD_W'(rd);
    res_o.write_ok      = wok;
    res_o.rejected      = rej;
  end

  // sequencer state and pin registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
      phase_q <= 1'b0;
      acc_q   <= '0;
      poll_q  <= '0;
      cs_q    <= 1'b0;
      sclk_q  <= 1'b0;
      di_q    <= 1'b0;
    end else begin
      step_q  <= step_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      poll_q  <= poll_d;
      cs_q    <= cs_d;
      sclk_q  <= sclk_d;
      di_q    <= di_d;
    end
  end

  // poll limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  `MW_ASSERT(a_idle_cs_low, (step_q == ST_IDLE) |-> !cs_q, "select high while idle")
  `MW_ASSERT(a_cnt_range, cnt_q <= CNT_W'(FRAME_LEN), "bit counter beyond frame length")
  `MW_ASSERT(a_reject_holds, (item_valid_i && is_cmd && step_q != ST_IDLE) |=> $stable(step_q) && $stable(cnt_q) && $stable(phase_q), "rejected command moved the sequencer")
  `MW_ASSERT(a_done_idle, (item_valid_i && done) |=> (step_q == ST_IDLE) && !cs_q, "sequence end did not return to idle")

endmodule

[hw/rtl/mw_obuf.sv]
`include "microwire_eeprom_master_top_macros.svh"

module mw_obuf import mw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  mw_out_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output mw_out_t out_data_o
);

  logic [1:0] count_q, count_d;
  mw_out_t    head_q;
  mw_out_t    tail_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = head_q;

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // two entry result store, head is presented on the port
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i) begin
        head_q <= push_data_i;
      end else begin
        head_q <= tail_q;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        head_q <= push_data_i;
      end else begin
        tail_q <= push_data_i;
      end
    end
  end

  `MW_ASSERT(a_count_range, count_q != 2'd3, "result queue count out of range")
  `MW_ASSERT(a_no_push_full, !(push_i && count_q == 2'd2), "transfer into a full result queue")
  `MW_ASSERT(a_head_held, (out_valid_o && !out_ready_i) |=> $stable(head_q), "waiting result changed")

endmodule

[hw/rtl/microwire_eeprom_master_top.sv]
// Microwire master for a three-wire serial EEPROM of 64 words of 16 bits. Every input
// transfer is one item: a tick that advances the serial link by one step, half a bit period
// while a frame shifts, or a read or write command, which is taken only while idle (a command
// while busy is dropped and flagged rejected). Every item yields exactly one result transfer
// with the pin levels after the step, busy, a done pulse and the read word or write status.
// Items are taken at one per clock; the whole sequencer step for an item is evaluated in the
// cycle it is accepted, and its result is registered in a two entry output queue and shown
// once earlier results are taken, so input ready drops only when that queue holds two
// unclaimed results. The user must write the poll limit register through cfg_we_i only while
// no sequence is running; the block does not enforce it. A value of zero acts as one.
module microwire_eeprom_master_top import mw_pkg::*; #(
  parameter int unsigned ADDR_BITS = 6,
  parameter int unsigned DATA_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [POLL_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mw_in_t            in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mw_out_t           out_data_o
);

  logic    full;
  logic    in_xfer;
  mw_out_t res;

  assign in_ready_o = !full;
  assign in_xfer    = in_valid_i && in_ready_o;

  // sequencer
  mw_core #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (in_xfer),
    .item_i       (in_data_i),
    .res_o        (res)
  );

  // result queue
  mw_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/tb_microwire_eeprom_master_top.sv]
module tb_microwire_eeprom_master_top;
  import mw_pkg::*;

  // spare mode code, behaves as a tick
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned CMD_LEN = 9;
  localparam int unsigned WRITE_FRAME_LEN = 25;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 600;

  // sequencer steps of the serial link
  typedef enum logic [3:0] {
    LS_IDLE, LS_EWEN, LS_GAP_W, LS_WRITE, LS_DUM_RISE, LS_DUM_FALL,
    LS_POLL_SEL, LS_POLL, LS_GAP_D, LS_EWDS, LS_RD_ADDR, LS_RD_DATA
  } link_step_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [POLL_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  mw_in_t            in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  mw_out_t           out_data_o;

  microwire_eeprom_master_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // link model state
  link_step_e        seq_step = LS_IDLE;
  logic [24:0]       frame_bits = '0;
  int unsigned       bits_left = 0;
  logic              half_high = 1'b0;
  logic [WORD_W-1:0] rx_word = '0;
  logic [POLL_W-1:0] poll_count = '0;
  logic              cmd_write = 1'b0;
  logic              pin_cs = 1'b0;
  logic              pin_clk = 1'b0;
  logic              pin_di = 1'b0;
  logic [POLL_W-1:0] poll_limit = POLL_LIMIT_RST;

  mw_out_t     pin_results_q[$];
  int unsigned fail_count = 0;
  int unsigned items_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // current frame bit at position bits_left - 1
  function automatic logic frame_bit();
    logic [24:0] pat;
    logic [4:0]  idx;
    if (bits_left == 0) return 1'b0;
    case (seq_step)
      LS_EWEN: pat = {16'h0, OP_EWX, 6'h3F};
      LS_EWDS: pat = {16'h0, OP_EWX, 6'h00};
      default: pat = frame_bits;
    endcase
    idx = 5'(bits_left - 1);
    return pat[idx];
  endfunction

  // one half bit of a frame, true when its last falling edge is done
  function automatic bit clock_half();
    if (!half_high) begin
      half_high = 1'b1;
      pin_clk = 1'b1;
      return 1'b0;
    end
    half_high = 1'b0;
    pin_clk = 1'b0;
    if (bits_left > 0) bits_left--;
    if (bits_left != 0) begin
      pin_di = frame_bit();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the link model by one item and give the pin state after it
  function automatic mw_out_t eeprom_link_step(mw_in_t it);
    mw_out_t           r;
    logic [POLL_W-1:0] lim;
    logic              done_now;
    logic              rej_now;
    logic              wok_now;
    logic [WORD_W-1:0] rd_now;
    done_now = 1'b0;
    rej_now = 1'b0;
    wok_now = 1'b0;
    rd_now = '0;
    lim = (poll_limit == '0) ? 14'd1 : poll_limit;
    if (it.mode == MODE_READ || it.mode == MODE_WRITE) begin
      if (seq_step != LS_IDLE) begin
        rej_now = 1'b1;
      end else begin
        cmd_write = (it.mode == MODE_WRITE);
        half_high = 1'b0;
        bits_left = CMD_LEN;
        rx_word = '0;
        poll_count = '0;
        if (cmd_write) begin
          frame_bits = {OP_WRITE, it.word_index, it.write_word};
          seq_step = LS_EWEN;
        end else begin
          frame_bits = {16'h0, OP_READ, it.word_index};
          seq_step = LS_RD_ADDR;
        end
        pin_cs = 1'b1;
        pin_clk = 1'b0;
        pin_di = 1'b1;
      end
    end else begin
      case (seq_step)
        LS_IDLE: ;
        LS_EWEN: if (clock_half()) begin
          pin_cs = 1'b0;
          seq_step = LS_GAP_W;
        end
        LS_GAP_W: begin
          seq_step = LS_WRITE;
          bits_left = WRITE_FRAME_LEN;
          half_high = 1'b0;
          pin_cs = 1'b1;
          pin_di = frame_bit();
        end
        LS_WRITE: if (clock_half()) begin
          pin_cs = 1'b0;
          pin_di = 1'b0;
          seq_step = LS_DUM_RISE;
        end
        LS_DUM_RISE: begin
          pin_clk = 1'b1;
          seq_step = LS_DUM_FALL;
        end
        LS_DUM_FALL: begin
          pin_clk = 1'b0;
          seq_step = LS_POLL_SEL;
        end
        LS_POLL_SEL: begin
          pin_cs = 1'b1;
          poll_count = '0;
          seq_step = LS_POLL;
        end
        LS_POLL: begin
          if (it.data_out_level) begin
            rx_word = 16'd1;
            pin_cs = 1'b0;
            seq_step = LS_GAP_D;
          end else begin
            if (poll_count < POLL_MAX) poll_count++;
            if (poll_count >= lim) begin
              rx_word = '0;
              pin_cs = 1'b0;
              seq_step = LS_GAP_D;
            end
          end
        end
        LS_GAP_D: begin
          seq_step = LS_EWDS;
          bits_left = CMD_LEN;
          half_high = 1'b0;
          pin_cs = 1'b1;
          pin_di = frame_bit();
        end
        LS_EWDS: if (clock_half()) begin
          pin_cs = 1'b0;
          seq_step = LS_IDLE;
          done_now = 1'b1;
          wok_now = rx_word[0];
        end
        LS_RD_ADDR: if (clock_half()) begin
          seq_step = LS_RD_DATA;
          bits_left = WORD_W;
          rx_word = '0;
        end
        LS_RD_DATA: begin
          if (!half_high) begin
            half_high = 1'b1;
            pin_clk = 1'b1;
          end else begin
            half_high = 1'b0;
            pin_clk = 1'b0;
            rx_word = {rx_word[WORD_W-2:0], it.data_out_level};
            if (bits_left > 0) bits_left--;
            if (bits_left == 0) begin
              pin_cs = 1'b0;
              seq_step = LS_IDLE;
              done_now = 1'b1;
              rd_now = rx_word;
            end
          end
        end
        default: seq_step = LS_IDLE;
      endcase
    end
    r.chip_select = pin_cs;
    r.serial_clock = pin_clk;
    r.data_in_level = pin_di;
    r.busy_res = (seq_step != LS_IDLE);
    r.done_res = done_now;
    r.read_result = rd_now;
    r.write_ok = wok_now;
    r.rejected = rej_now;
    return r;
  endfunction

  // one input transfer, with a random idle gap before it
  task automatic send_item(mw_in_t it);
    int unsigned gap;
    mw_out_t     r;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r = eeprom_link_step(it);
    pin_results_q.push_back(r);
    if (!r.rejected) items_taken++;
  endtask

  // tick, or with noise_pct a command that lands while busy
  task automatic send_tick(int unsigned one_pct, int unsigned noise_pct);
    mw_in_t it;
    it.mode = ($urandom_range(3) == 0) ? MODE_SPARE : MODE_TICK;
    if ($urandom_range(99) < noise_pct) it.mode = $urandom_range(1) ? MODE_READ : MODE_WRITE;
    it.word_index = IDX_IN_W'($urandom_range(63));
    it.write_word = WORD_W'($urandom_range(16'hFFFF));
    it.data_out_level = ($urandom_range(99) < one_pct);
    send_item(it);
  endtask

  // full command sequence from an idle link back to idle
  task automatic run_command(logic [MODE_W-1:0] mode, logic [IDX_IN_W-1:0] addr,
                             logic [WORD_W-1:0] word, int unsigned one_pct,
                             int unsigned noise_pct);
    mw_in_t it;
    it.mode = mode;
    it.word_index = addr;
    it.write_word = word;
    it.data_out_level = 1'($urandom_range(1));
    send_item(it);
    while (seq_step != LS_IDLE) send_tick(one_pct, noise_pct);
  endtask

  // random address and data for a command
  function automatic logic [IDX_IN_W-1:0] rand_addr();
    return IDX_IN_W'($urandom_range(63));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom_range(16'hFFFF));
  endfunction

  // stop sending and wait for every pending result
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk_i);
  endtask

  // poll limit register write while the link is idle
  task automatic set_poll_limit(logic [POLL_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    poll_limit = value;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_bit(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // reads at both address extremes with all-ones and all-zero data, idle ticks around
  task automatic test_read_extremes();
    set_idling(0, 0);
    repeat (3) send_tick(50, 0);
    run_command(MODE_READ, 6'h3F, 16'hFFFF, 100, 0);
    run_command(MODE_READ, 6'h00, 16'h0000, 0, 0);
    repeat (2) send_tick(50, 0);
  endtask

  // writes under the poll limit left by reset
  task automatic test_write_default_limit();
    run_command(MODE_WRITE, 6'h3F, 16'hFFFF, 10, 0);
    run_command(MODE_WRITE, 6'h00, 16'h0000, 10, 0);
  endtask

  // commands arriving mid sequence are dropped
  task automatic test_busy_rejects();
    run_command(MODE_READ, rand_addr(), rand_word(), 50, 40);
    run_command(MODE_WRITE, rand_addr(), rand_word(), 20, 40);
  endtask

  // zero limit acts as one, then the smallest and largest limits
  task automatic test_poll_limit_edges();
    set_poll_limit(14'd0);
    run_command(MODE_WRITE, rand_addr(), rand_word(), 0, 0);
    set_poll_limit(14'd1);
    run_command(MODE_WRITE, rand_addr(), rand_word(), 100, 0);
    run_command(MODE_WRITE, rand_addr(), rand_word(), 0, 0);
    set_poll_limit(POLL_MAX);
    run_command(MODE_WRITE, rand_addr(), rand_word(), 1, 0);
    run_command(MODE_WRITE, rand_addr(), rand_word(), 5, 0);
  endtask

  // random commands over all idling phases, small poll limits
  task automatic test_random_traffic();
    int unsigned first;
    int unsigned phase;
    first = items_taken;
    set_poll_limit(POLL_W'($urandom_range(1, 40)));
    while (items_taken - first < RANDOM_ITEMS) begin
      phase = ((items_taken - first) / 150) % 4;
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(52, 0);
        2: set_idling(0, 52);
        default: set_idling(23, 23);
      endcase
      if ($urandom_range(3) == 0)
        set_poll_limit(($urandom_range(7) == 0) ? 14'd0 : 14'($urandom_range(1, 40)));
      repeat ($urandom_range(3)) send_tick(50, 0);
      run_command($urandom_range(1) ? MODE_READ : MODE_WRITE, rand_addr(),
                  rand_word(), $urandom_range(100), 8);
    end
  endtask

  // receiver ready, stalling at the phase rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // compare each result transfer with the oldest predicted pin state
  always @(posedge clk_i) begin
    mw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pin_results_q.size() == 0) begin
        $error("result transfer with nothing pending");
        fail_count++;
      end else begin
        want = pin_results_q.pop_front();
        check_bit("chip_select", want.chip_select, out_data_o.chip_select);
        check_bit("serial_clock", want.serial_clock, out_data_o.serial_clock);
        check_bit("data_in_level", want.data_in_level, out_data_o.data_in_level);
        check_bit("busy_res", want.busy_res, out_data_o.busy_res);
        check_bit("done_res", want.done_res, out_data_o.done_res);
        check_field("read_result", want.read_result, out_data_o.read_result);
        check_bit("write_ok", want.write_ok, out_data_o.write_ok);
        check_bit("rejected", want.rejected, out_data_o.rejected);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("microwire_eeprom_master_top regression: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_read_extremes();
    test_write_default_limit();
    test_busy_rejects();
    test_poll_limit_edges();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk_i);
    if (pin_results_q.size() != 0) begin
      $error("%0d results never arrived", pin_results_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("microwire_eeprom_master_top regression: pass");
    end else begin
      $display("microwire_eeprom_master_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mw_pkg.sv
hw/rtl/mw_core.sv
hw/rtl/mw_obuf.sv
hw/rtl/microwire_eeprom_master_top.sv
tb/tb_microwire_eeprom_master_top.sv
